>>> hw/rtl/cspd_pkg.sv
`timescale 1ns / 1ps
// shared constants for the same-port distance calendar
// no dependencies
package cspd_pkg;

	localparam int CAL_DEPTH    = 512;
	localparam int PORT_ID_BITS = 10;
	localparam int SLOT_BITS    = 9;
	localparam int LEN_BITS     = 10;
	localparam int DIST_BITS    = 9;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// used length: register value clamped to the calendar depth
	function automatic logic [LEN_BITS-1:0] used_length(input logic [LEN_BITS-1:0] cfg);
		logic [LEN_BITS-1:0] lim;
		lim = LEN_BITS'(CAL_DEPTH);
		return (cfg > lim) ? lim : cfg;
	endfunction

endpackage

>>> hw/rtl/calendar_same_port_distance.sv
`timescale 1ns / 1ps
// query flow: a write gives no word; a query reads the named slot, then makes one calendar read
//   per cycle until the first match or the last step, and a query that the slot or length rules
//   out skips the scan; the result then waits for a free output register
// throughput: one query at a time, bound by the single read port of the calendar memory
// reset: arst_n clears control state and the length register; the calendar is not cleared
// depends on cspd_pkg
module calendar_same_port_distance (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cspd_pkg::LEN_BITS-1:0]      cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [cspd_pkg::SLOT_BITS-1:0]     slot_index,
	input  logic [cspd_pkg::PORT_ID_BITS-1:0]  port_id,
	input  logic                               search_up,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cspd_pkg::DIST_BITS-1:0]     distance
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;  // take a word
	localparam logic [1:0] ST_WANT = 2'd1;  // identifier of the named slot arrives
	localparam logic [1:0] ST_SCAN = 2'd2;  // one compare per cycle, reads run one ahead
	localparam logic [1:0] ST_DONE = 2'd3;  // hand result to the output register

	logic [1:0]                          state_q;
	logic [cspd_pkg::LEN_BITS-1:0]       cal_len_q;

	// calendar storage, one synchronous read port, one write port
	logic [cspd_pkg::PORT_ID_BITS-1:0]   cal_mem [cspd_pkg::CAL_DEPTH];
	logic [cspd_pkg::PORT_ID_BITS-1:0]   rdata_q;
	logic [cspd_pkg::SLOT_BITS-1:0]      rd_addr;

	// scan bookkeeping
	logic [cspd_pkg::PORT_ID_BITS-1:0]   want_q;
	logic [cspd_pkg::SLOT_BITS-1:0]      k_q;      // next slot to read
	logic [cspd_pkg::SLOT_BITS-1:0]      n_q;      // step count of that read
	logic [cspd_pkg::SLOT_BITS-1:0]      n_s1;     // step count of the data in rdata_q
	logic [cspd_pkg::SLOT_BITS-1:0]      len_m1_q; // last step to try
	logic                                up_q;
	logic [cspd_pkg::DIST_BITS-1:0]      res_q;

	logic [cspd_pkg::DIST_BITS-1:0]      distance_q;
	logic                                out_valid_q;

	logic                                accept;
	logic                                acc_write;
	logic                                acc_query;
	logic [cspd_pkg::LEN_BITS-1:0]       len;
	logic [cspd_pkg::SLOT_BITS-1:0]      len_m1;
	logic                                trivial;
	logic [cspd_pkg::SLOT_BITS-1:0]      step_base;
	logic [cspd_pkg::SLOT_BITS-1:0]      step_lm1;
	logic                                step_dir;
	logic [cspd_pkg::SLOT_BITS-1:0]      k_next;
	logic                                load_out;
	logic                                hit;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign acc_write = accept && (req_type == cspd_pkg::REQ_WRITE);
	assign acc_query = accept && (req_type == cspd_pkg::REQ_QUERY);

	// clamp length; a query with fewer than two slots or outside the length answers zero
	assign len     = cspd_pkg::used_length(cal_len_q);
	assign len_m1  = cspd_pkg::SLOT_BITS'(len - cspd_pkg::LEN_BITS'(1));
	assign trivial = (len <= cspd_pkg::LEN_BITS'(1))
		|| ({1'b0, slot_index} >= len);

	// circular step: up walks to lower indices, down to higher, both wrap at len
	always_comb begin
		if (state_q == ST_IDLE) begin
			step_base = slot_index;
			step_lm1  = len_m1;
			step_dir  = search_up;
		end else begin
			step_base = k_q;
			step_lm1  = len_m1_q;
			step_dir  = up_q;
		end
		if (step_dir) begin
			k_next = (step_base == '0) ? step_lm1 : step_base - 1'b1;
		end else begin
			k_next = (step_base == step_lm1) ? '0 : step_base + 1'b1;
		end
	end

	// idle reads the named slot, otherwise the next slot of the scan
	assign rd_addr = (state_q == ST_IDLE) ? slot_index : k_q;

	always_ff @(posedge clk) begin
		if (acc_write) begin
			cal_mem[slot_index] <= port_id;
		end
		rdata_q <= cal_mem[rd_addr];
	end

	// compare of the word read last cycle against the wanted identifier
	assign hit      = (rdata_q == want_q);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_len_q <= '0;
		end else if (cfg_we) begin
			cal_len_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_query) begin
						state_q <= trivial ? ST_DONE : ST_WANT;
					end
				end
				ST_WANT: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hit || (n_s1 == len_m1_q)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan datapath; reads may run past the last step, their data is never used
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc_query) begin
					k_q      <= k_next;
					n_q      <= cspd_pkg::SLOT_BITS'(1);
					len_m1_q <= len_m1;
					up_q     <= search_up;
					res_q    <= '0;
				end
			end
			ST_WANT: begin
				want_q <= rdata_q;
				k_q    <= k_next;
				n_q    <= n_q + 1'b1;
				n_s1   <= n_q;
			end
			ST_SCAN: begin
				k_q  <= k_next;
				n_q  <= n_q + 1'b1;
				n_s1 <= n_q;
				if (hit) begin
					res_q <= cspd_pkg::DIST_BITS'(n_s1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register parts the result from the next request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			distance_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;

`ifndef SYNTHESIS
	// the scan never compares a step past the last one
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (n_s1 <= len_m1_q))
		else $error("scan step beyond calendar length");

	// a match ends the scan on the next edge
	a_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && hit) |=> (state_q == ST_DONE))
		else $error("match did not end scan");

	// a result handed over shows up as a valid word
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid && state_q == ST_IDLE))
		else $error("result not presented");

	// an accepted query blocks further words
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		acc_query |=> !in_ready)
		else $error("input taken during query");
`endif

endmodule
